### hw/rtl/assert_macros.svh
// Assertion macros for the row record decoder checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define RRD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("row_record_decoder check failed");

// Concurrent check that also holds across reset.
`define RRD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("row_record_decoder check failed");

`endif

### hw/rtl/rrd_pkg.sv
// Types and constants for the row record decoder.
// No dependencies.
`timescale 1ns / 1ps

package rrd_pkg;

  localparam int unsigned MAX_COLUMNS = 256;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned TYPE_W      = 5;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned LBL_W       = 3;

  localparam logic [CODE_W-1:0] CODE_NULL    = 3'd5;
  localparam logic [CODE_W-1:0] CODE_LEN_MIN = 3'd1;
  localparam logic [CODE_W-1:0] CODE_LEN_MAX = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  typedef enum logic [2:0] {
    K_VALUE   = 3'd0,
    K_NULL    = 3'd1,
    K_LENBYTE = 3'd2,
    K_PAYLOAD = 3'd3,
    K_END     = 3'd4,
    K_ERROR   = 3'd5,
    K_DISCARD = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_start;
  } item_t;

  typedef struct packed {
    kind_t              byte_kind;
    logic [INDEX_W-1:0] column_index;
    logic [TYPE_W-1:0]  column_type;
    logic [LEN_W-1:0]   column_length;
    logic [7:0]         payload_byte;
    logic               column_done;
    logic [COUNT_W-1:0] column_count;
  } result_t;

endpackage

### hw/rtl/rrd_in_stage.sv
// Input register of the row record decoder.
// Depends on rrd_pkg.
`timescale 1ns / 1ps

module rrd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  rrd_pkg::item_t s_item,
  input  logic           advance,
  output logic           valid,
  output rrd_pkg::item_t item
);

  assign s_axis_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= s_item;
    end
  end

endmodule

### hw/rtl/rrd_core.sv
// Column parser state and per-item classification.
// Depends on rrd_pkg.
`timescale 1ns / 1ps

module rrd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rrd_pkg::item_t   item,
  output rrd_pkg::result_t res
);

  rrd_pkg::phase_t                      phase, phase_next, ph;
  logic [rrd_pkg::LBL_W-1:0]            lbl, lbl_next, lb;
  logic [rrd_pkg::LEN_W-1:0]            acc, acc_next, ac;
  logic [rrd_pkg::LEN_W-1:0]            pleft, pleft_next, pl;
  logic [rrd_pkg::COUNT_W-1:0]          col, col_next, cc;
  logic [rrd_pkg::TYPE_W-1:0]           ctype, ctype_next;
  logic [rrd_pkg::CODE_W-1:0]           code;
  logic [7:0]                           b;
  logic [rrd_pkg::LEN_W-1:0]            acc_shift;

  assign b         = item.data_byte;
  assign code      = b[rrd_pkg::CODE_W-1:0];
  assign acc_shift = {ac[rrd_pkg::LEN_W-9:0], b};

  always_comb begin
    ph = item.row_start ? rrd_pkg::PH_HEADER : phase;
    cc = item.row_start ? '0 : col;
    lb = item.row_start ? '0 : lbl;
    ac = item.row_start ? '0 : acc;
    pl = item.row_start ? '0 : pleft;

    phase_next = ph;
    lbl_next   = lb;
    acc_next   = ac;
    pleft_next = pl;
    col_next   = cc;
    ctype_next = ctype;

    res.byte_kind     = rrd_pkg::K_DISCARD;
    res.column_index  = cc[rrd_pkg::INDEX_W-1:0];
    res.column_length = '0;
    res.payload_byte  = '0;
    res.column_done   = 1'b0;

    unique case (ph)
      rrd_pkg::PH_HEADER: begin
        if (b == 8'd0) begin
          res.byte_kind = rrd_pkg::K_END;
          ctype_next    = '0;
          col_next      = '0;
        end else begin
          ctype_next = b[7:3];
          if (cc >= rrd_pkg::COUNT_W'(rrd_pkg::MAX_COLUMNS)) begin
            res.byte_kind = rrd_pkg::K_ERROR;
            phase_next    = rrd_pkg::PH_DISCARD;
          end else if (code == rrd_pkg::CODE_NULL) begin
            res.byte_kind   = rrd_pkg::K_NULL;
            res.column_done = 1'b1;
            col_next        = cc + 1'b1;
          end else if (code >= rrd_pkg::CODE_LEN_MIN && code <= rrd_pkg::CODE_LEN_MAX) begin
            res.byte_kind = rrd_pkg::K_VALUE;
            lbl_next      = code;
            acc_next      = '0;
            phase_next    = rrd_pkg::PH_LENGTH;
          end else begin
            res.byte_kind = rrd_pkg::K_ERROR;
            phase_next    = rrd_pkg::PH_DISCARD;
          end
        end
      end
      rrd_pkg::PH_LENGTH: begin
        res.byte_kind     = rrd_pkg::K_LENBYTE;
        acc_next          = acc_shift;
        res.column_length = acc_shift;
        lbl_next          = (lb != '0) ? lb - 1'b1 : lb;
        if (lbl_next == '0) begin
          pleft_next = acc_shift;
          if (acc_shift == '0) begin
            res.column_done = 1'b1;
            col_next        = cc + 1'b1;
            phase_next      = rrd_pkg::PH_HEADER;
          end else begin
            phase_next = rrd_pkg::PH_PAYLOAD;
          end
        end
      end
      rrd_pkg::PH_PAYLOAD: begin
        res.byte_kind     = rrd_pkg::K_PAYLOAD;
        res.payload_byte  = b;
        res.column_length = ac;
        pleft_next        = (pl != '0) ? pl - 1'b1 : pl;
        if (pleft_next == '0) begin
          res.column_done = 1'b1;
          col_next        = cc + 1'b1;
          phase_next      = rrd_pkg::PH_HEADER;
        end
      end
      default: begin
        res.byte_kind = rrd_pkg::K_DISCARD;
      end
    endcase

    res.column_type  = ctype_next;
    res.column_count = (res.byte_kind == rrd_pkg::K_END) ? cc : col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rrd_pkg::PH_HEADER;
      lbl   <= '0;
      acc   <= '0;
      pleft <= '0;
      col   <= '0;
      ctype <= '0;
    end else if (step) begin
      phase <= phase_next;
      lbl   <= lbl_next;
      acc   <= acc_next;
      pleft <= pleft_next;
      col   <= col_next;
      ctype <= ctype_next;
    end
  end

endmodule

### hw/rtl/row_record_decoder.sv
// Top level of the row record decoder: input register, parser, result register.
// Depends on rrd_pkg, rrd_in_stage and rrd_core.
//
//   channel  | direction | tdata                           | tuser     | tlast
//   s_axis   | in        | data_byte                       | row_start | -
//   m_axis   | out       | index,type,length,payload,count | byte_kind | column_done
//
// One byte per cycle unless the result stalls; a byte crosses both registers.
// The rate is set by the combinational parser update between the two registers.
// Reset clears the parser state and both valid flags; a row starts at column 0.
// A stalled result holds the result register; the input register then fills
// and s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps

module row_record_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] row_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [7:0] column_index, [12:8] column_type,
                                     // [44:13] column_length, [52:45] payload_byte,
                                     // [61:53] column_count, [63:62] zero
  output logic [2:0]  m_axis_tuser,  // [2:0] byte_kind
  output logic        m_axis_tlast   // column_done
);

  rrd_pkg::item_t   s_item, item;
  rrd_pkg::result_t res, out_res;
  logic             in_valid;
  logic             advance;
  logic             step;

  assign s_item.data_byte = s_axis_tdata;
  assign s_item.row_start = s_axis_tuser;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign step    = in_valid && advance;

  rrd_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_item        (s_item),
    .advance       (advance),
    .valid         (in_valid),
    .item          (item)
  );

  rrd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.column_count, out_res.payload_byte,
                         out_res.column_length, out_res.column_type,
                         out_res.column_index};
  assign m_axis_tuser = out_res.byte_kind;
  assign m_axis_tlast = out_res.column_done;

endmodule

### hw/rtl/rrd_checker.sv
// Port-level checks for the row record decoder, bound to the top level.
// Depends on assert_macros.svh and rrd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [2:0]  kind;
  logic        done;
  logic        done_kind;
  logic        is_payload;
  logic        pay_zero;
  logic        stalled;
  logic [8:0]  count_less;
  logic [8:0]  index_ext;
  logic [67:0] m_bus;

  assign kind       = m_axis_tuser;
  assign done       = m_axis_tlast;
  assign done_kind  = (kind == rrd_pkg::K_NULL) || (kind == rrd_pkg::K_LENBYTE) ||
                      (kind == rrd_pkg::K_PAYLOAD);
  assign is_payload = (kind == rrd_pkg::K_PAYLOAD);
  assign pay_zero   = (m_axis_tdata[52:45] == 8'd0);
  assign stalled    = m_axis_tvalid && !m_axis_tready;
  assign count_less = m_axis_tdata[61:53] - 9'd1;
  assign index_ext  = {1'b0, m_axis_tdata[7:0]};
  assign m_bus      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `RRD_ASSERT_NR(a_idle_after_reset, clk, rst |=> !m_axis_tvalid)
  `RRD_ASSERT(a_stall_holds, clk, rst, stalled |=> m_axis_tvalid && $stable(m_bus))
  `RRD_ASSERT(a_done_kinds, clk, rst, m_axis_tvalid && done |-> done_kind)
  `RRD_ASSERT(a_done_count, clk, rst, m_axis_tvalid && done |-> count_less == index_ext)
  `RRD_ASSERT(a_payload_only, clk, rst, m_axis_tvalid && !is_payload |-> pay_zero)

endmodule

bind row_record_decoder rrd_checker u_rrd_checker (.*);
